// File: src/wds_pkg.sv
// Package for the wave dispersion solver: sequencer states, unit request
// structs and fixed-point constants. No dependencies.
package wds_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_W2, S_L0, S_TPH, S_X0, S_SQRT, S_XX, S_D30, S_D6, S_S0,
    S_TANH, S_EMUL, S_EDIV, S_INVE, S_EFIN, S_TDIV, S_LEN, S_LMUL,
    S_XDIV, S_NUM, S_NDIV, S_OUT
  } state_t;

  typedef struct packed {
    logic        go;
    logic [35:0] a;
    logic [35:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        go;
    logic [63:0] n;
    logic [63:0] d;
  } div_req_t;

  localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
  localparam logic [37:0] TWO_PI_G_Q32 = 38'd264733399763;
  localparam logic [30:0] INV_E_Q32    = 31'd1580030169;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [29:0] X_SAT        = 30'd805306368;  // 12.0 in Q26
  localparam logic [34:0] POLY_ONE     = 35'h400_0000;   // 1.0 in Q26
  localparam logic [6:0]  ITERATIONS   = 7'd100;
  localparam logic [3:0]  EXP_TERMS    = 4'd14;
  localparam logic [4:0]  SQRT_LAST    = 5'd31;
  localparam logic [23:0] DEPTH_RESET  = 24'd40960;
  localparam logic [5:0]  MUL_LAST     = 6'd35;
  localparam logic [5:0]  DIV_LAST     = 6'd63;

endpackage

// File: src/wds_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on wds_pkg (mul_req_t). Product is kept modulo 2^64.
module wds_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  wds_pkg::mul_req_t req,
  output logic             done,
  output logic [63:0]      p
);
  import wds_pkg::*;

  logic [63:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [35:0] b_r, b_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;

  // one partial product per step
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      a_nxt   = {28'b0, req.a};
      b_nxt   = req.b;
      acc_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = {a_r[62:0], 1'b0};
      b_nxt   = {1'b0, b_r[35:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == MUL_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// File: src/wds_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wds_pkg (div_req_t). Divisor must be nonzero.
module wds_div (
  input  logic             clk,
  input  logic             rst_n,
  input  wds_pkg::div_req_t req,
  output logic             done,
  output logic [63:0]      q
);
  import wds_pkg::*;

  logic [64:0] rem_r, rem_nxt, trial;
  logic [63:0] quo_r, quo_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt, ge;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    trial    = {rem_r[63:0], quo_r[63]};
    ge       = (trial >= {1'b0, d_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = req.n;
      d_nxt   = req.d;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? (trial - {1'b0, d_r}) : trial;
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == DIV_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign q    = quo_r;
endmodule

// File: src/wave_dispersion_solver.sv
// Top level of the wave dispersion solver: sequencer and datapath registers.
// Depends on wds_pkg, wds_mul and wds_div.
//
// Usage: drive in_* and raise start; the item is taken at a clock edge with
// start high and busy low. busy stays high until the result has been shown.
// The result appears on out_* for one cycle with out_valid high; the receiver
// cannot stall it, so it must take it in that cycle.
// cfg_data (depth, Q12.12) is written when cfg_valid is high; cfg_ready is
// always high. Write it only while busy is low.
// A zero-frequency item goes straight to the result. Otherwise a setup runs
// and then 101 passes of tanh; below saturation each takes 14 exp Taylor
// terms and n rounded multiplies by 1/e, n = integer part of 2x (0..23).
// All steps use one shared shift-add multiplier and one shared restoring
// divider.
// One item at a time: the next is taken no earlier than the cycle after out_valid.
// Reset (rst_n low, synchronous) returns to idle and sets depth to 10 m.
module wave_dispersion_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_amplitude,
  input  logic [23:0] in_angular_frequency,
  input  logic [23:0] in_phase,
  input  logic        in_last_component,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_wave_length,
  output logic [31:0] out_wave_number,
  output logic [23:0] out_amplitude_out,
  output logic [23:0] out_phase_out,
  output logic        out_bad_input,
  output logic        out_last_out
);
  import wds_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0] depth_r, h_eff;
  logic [23:0] amp_r, amp_nxt, ph_r, ph_nxt;
  logic        last_r, last_nxt, bad_r, bad_nxt;
  logic [31:0] l0_r, l0_nxt, x0_r, x0_nxt, len_r, len_nxt, num_r, num_nxt;
  logic [31:0] f_r, f_nxt;
  logic [58:0] tph_r, tph_nxt;
  logic [34:0] poly_r, poly_nxt;
  logic [29:0] x_r, x_nxt;
  logic [4:0]  n_r, n_nxt, sq_cnt_r, sq_cnt_nxt;
  logic [32:0] term_r, term_nxt, e_r, e_nxt, th_r, th_nxt;
  logic signed [35:0] sum_r, sum_nxt, sum_upd;
  logic [3:0]  k_r, k_nxt;
  logic [6:0]  iter_r, iter_nxt;
  logic [63:0] sq_v_r, sq_v_nxt, sq_root_r, sq_root_nxt, sq_bit_r, sq_bit_nxt;
  logic [63:0] sq_sum;
  logic        sq_ge;

  mul_req_t    mul_req;
  div_req_t    div_req;
  logic        mul_done, div_done;
  logic [63:0] mul_p, div_q;

  logic [63:0] e_rnd;
  logic [32:0] e_clamp, e_new, one_m_e;
  logic [33:0] one_p_e;
  logic        iter_done, len_zero;

  wds_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .done(mul_done), .p(mul_p));
  wds_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .q(div_q));

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [29:0] sat_x(input logic [63:0] v);
    return (v >= {34'd0, X_SAT}) ? X_SAT : v[29:0];
  endfunction

  // shared conditions
  assign h_eff     = (depth_r == 24'd0) ? 24'd1 : depth_r;
  assign iter_done = (iter_r == ITERATIONS);
  assign len_zero  = (mul_p[63:32] == 32'd0);
  assign sum_upd   = k_r[0] ? (sum_r - $signed({3'b0, div_q[32:0]}))
                            : (sum_r + $signed({3'b0, div_q[32:0]}));
  assign e_clamp   = (sum_upd < 0) ? 33'd0 :
                     (sum_upd > $signed({3'b0, ONE_Q32})) ? ONE_Q32 : sum_upd[32:0];
  assign e_rnd     = mul_p + 64'h8000_0000;
  assign e_new     = {1'b0, e_rnd[63:32]};
  assign one_m_e   = ONE_Q32 - e_r;
  assign one_p_e   = {1'b0, ONE_Q32} + {1'b0, e_r};
  assign sq_sum    = sq_root_r + sq_bit_r;
  assign sq_ge     = (sq_v_r >= sq_sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = (in_angular_frequency == 24'd0) ? S_OUT : S_W2;
      S_W2:   if (mul_done) state_nxt = S_L0;
      S_L0:   if (div_done) state_nxt = S_TPH;
      S_TPH:  if (mul_done) state_nxt = S_X0;
      S_X0:   if (div_done) state_nxt = S_SQRT;
      S_SQRT: if (sq_cnt_r == SQRT_LAST) state_nxt = S_XX;
      S_XX:   if (mul_done) state_nxt = S_D30;
      S_D30:  if (div_done) state_nxt = S_D6;
      S_D6:   if (div_done) state_nxt = S_S0;
      S_S0:   if (mul_done) state_nxt = S_TANH;
      S_TANH: state_nxt = (x_r == X_SAT) ? S_LEN : S_EMUL;
      S_EMUL: if (mul_done) state_nxt = S_EDIV;
      S_EDIV: begin
        if (div_done) begin
          if (k_r == EXP_TERMS) state_nxt = (n_r == 5'd0) ? S_EFIN : S_INVE;
          else                  state_nxt = S_EMUL;
        end
      end
      S_INVE: if (mul_done && n_r == 5'd1) state_nxt = S_EFIN;
      S_EFIN: state_nxt = (e_r == 33'd0) ? S_LEN : S_TDIV;
      S_TDIV: if (div_done) state_nxt = S_LEN;
      S_LEN:  state_nxt = S_LMUL;
      S_LMUL: begin
        if (mul_done) begin
          if (iter_done)     state_nxt = S_NUM;
          else if (len_zero) state_nxt = S_LEN;
          else               state_nxt = S_XDIV;
        end
      end
      S_XDIV: if (div_done) state_nxt = S_TANH;
      S_NUM:  state_nxt = (len_r == 32'd0) ? S_OUT : S_NDIV;
      S_NDIV: if (div_done) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath updates and unit requests
  always_comb begin
    amp_nxt = amp_r;  ph_nxt = ph_r;  last_nxt = last_r;  bad_nxt = bad_r;
    l0_nxt = l0_r;  x0_nxt = x0_r;  len_nxt = len_r;  num_nxt = num_r;
    f_nxt = f_r;  tph_nxt = tph_r;  poly_nxt = poly_r;  x_nxt = x_r;
    n_nxt = n_r;  term_nxt = term_r;  e_nxt = e_r;  th_nxt = th_r;
    sum_nxt = sum_r;  k_nxt = k_r;  iter_nxt = iter_r;
    sq_v_nxt = sq_v_r;  sq_root_nxt = sq_root_r;  sq_bit_nxt = sq_bit_r;
    sq_cnt_nxt = sq_cnt_r;
    mul_req = '0;
    div_req = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          amp_nxt  = in_amplitude;
          ph_nxt   = in_phase;
          last_nxt = in_last_component;
          bad_nxt  = (in_angular_frequency == 24'd0);
          len_nxt  = '0;
          num_nxt  = '0;
          iter_nxt = '0;
          mul_req.go = (in_angular_frequency != 24'd0);
          mul_req.a  = {12'b0, in_angular_frequency};
          mul_req.b  = {12'b0, in_angular_frequency};
        end
      end
      // deep-water length, rounded
      S_W2: begin
        if (mul_done) begin
          div_req.go = 1'b1;
          div_req.n  = {4'b0, TWO_PI_G_Q32, 22'b0} + {17'b0, mul_p[47:1]};
          div_req.d  = {16'b0, mul_p[47:0]};
        end
      end
      S_L0: begin
        if (div_done) begin
          l0_nxt     = sat32(div_q);
          mul_req.go = 1'b1;
          mul_req.a  = {1'b0, TWO_PI_Q32};
          mul_req.b  = {12'b0, h_eff};
        end
      end
      S_TPH: begin
        if (mul_done) begin
          tph_nxt    = mul_p[58:0];
          div_req.go = 1'b1;
          div_req.n  = {5'b0, mul_p[58:0]};
          div_req.d  = {32'b0, l0_r};
        end
      end
      S_X0: begin
        if (div_done) begin
          x0_nxt      = sat32(div_q);
          sq_v_nxt    = {6'b0, sat32(div_q), 26'b0};
          sq_root_nxt = '0;
          sq_bit_nxt  = 64'h4000_0000_0000_0000;
          sq_cnt_nxt  = '0;
        end
      end
      // integer square root, two bits per step
      S_SQRT: begin
        sq_v_nxt    = sq_ge ? (sq_v_r - sq_sum) : sq_v_r;
        sq_root_nxt = sq_ge ? ({1'b0, sq_root_r[63:1]} + sq_bit_r)
                            : {1'b0, sq_root_r[63:1]};
        sq_bit_nxt  = {2'b0, sq_bit_r[63:2]};
        sq_cnt_nxt  = sq_cnt_r + 5'd1;
        if (sq_cnt_r == SQRT_LAST) begin
          mul_req.go = 1'b1;
          mul_req.a  = {4'b0, x0_r};
          mul_req.b  = {4'b0, x0_r};
        end
      end
      S_XX: begin
        if (mul_done) begin
          div_req.go = 1'b1;
          div_req.n  = {26'b0, mul_p[63:26]};
          div_req.d  = 64'd30;
        end
      end
      S_D30: begin
        if (div_done) begin
          poly_nxt   = POLY_ONE + div_q[34:0];
          div_req.go = 1'b1;
          div_req.n  = {32'b0, x0_r};
          div_req.d  = 64'd6;
        end
      end
      S_D6: begin
        if (div_done) begin
          mul_req.go = 1'b1;
          mul_req.a  = {7'b0, sq_root_r[28:0]};
          mul_req.b  = {1'b0, poly_r + div_q[34:0]};
        end
      end
      S_S0: begin
        if (mul_done) x_nxt = sat_x({26'b0, mul_p[63:26]});
      end
      // tanh entry: split 2x into integer and fraction
      S_TANH: begin
        if (x_r == X_SAT) begin
          th_nxt = ONE_Q32;
        end else begin
          n_nxt      = x_r[29:25];
          f_nxt      = {x_r[24:0], 7'b0};
          term_nxt   = ONE_Q32;
          sum_nxt    = $signed({3'b0, ONE_Q32});
          k_nxt      = 4'd1;
          mul_req.go = 1'b1;
          mul_req.a  = {3'b0, ONE_Q32};
          mul_req.b  = {4'b0, x_r[24:0], 7'b0};
        end
      end
      S_EMUL: begin
        if (mul_done) begin
          div_req.go = 1'b1;
          div_req.n  = {32'b0, mul_p[63:32]};
          div_req.d  = {60'b0, k_r};
        end
      end
      // Taylor term accumulate
      S_EDIV: begin
        if (div_done) begin
          term_nxt = div_q[32:0];
          sum_nxt  = sum_upd;
          if (k_r == EXP_TERMS) begin
            e_nxt      = e_clamp;
            mul_req.go = (n_r != 5'd0);
            mul_req.a  = {3'b0, e_clamp};
            mul_req.b  = {5'b0, INV_E_Q32};
          end else begin
            k_nxt      = k_r + 4'd1;
            mul_req.go = 1'b1;
            mul_req.a  = {3'b0, div_q[32:0]};
            mul_req.b  = {4'b0, f_r};
          end
        end
      end
      // integer part: rounded multiplies by 1/e
      S_INVE: begin
        if (mul_done) begin
          e_nxt      = e_new;
          n_nxt      = n_r - 5'd1;
          mul_req.go = (n_r != 5'd1);
          mul_req.a  = {3'b0, e_new};
          mul_req.b  = {5'b0, INV_E_Q32};
        end
      end
      S_EFIN: begin
        if (e_r == 33'd0) begin
          th_nxt = ONE_Q32;
        end else begin
          div_req.go = 1'b1;
          div_req.n  = {one_m_e[31:0], 32'b0} + {31'b0, one_p_e[33:1]};
          div_req.d  = {30'b0, one_p_e};
        end
      end
      S_TDIV: begin
        if (div_done) th_nxt = div_q[32:0];
      end
      S_LEN: begin
        mul_req.go = 1'b1;
        mul_req.a  = {4'b0, l0_r};
        mul_req.b  = {3'b0, th_r};
      end
      // new length; next depth ratio
      S_LMUL: begin
        if (mul_done) begin
          len_nxt = mul_p[63:32];
          if (!iter_done) begin
            iter_nxt = iter_r + 7'd1;
            if (len_zero) begin
              th_nxt = ONE_Q32;
            end else begin
              div_req.go = 1'b1;
              div_req.n  = {5'b0, tph_r};
              div_req.d  = {32'b0, mul_p[63:32]};
            end
          end
        end
      end
      S_XDIV: begin
        if (div_done) x_nxt = sat_x(div_q);
      end
      S_NUM: begin
        if (len_r == 32'd0) begin
          num_nxt = 32'hFFFF_FFFF;
        end else begin
          div_req.go = 1'b1;
          div_req.n  = {19'b0, TWO_PI_Q32, 10'b0} + {33'b0, len_r[31:1]};
          div_req.d  = {32'b0, len_r};
        end
      end
      S_NDIV: begin
        if (div_done) num_nxt = sat32(div_q);
      end
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    cfg_ready = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= DEPTH_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) depth_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    amp_r <= amp_nxt;  ph_r <= ph_nxt;  last_r <= last_nxt;  bad_r <= bad_nxt;
    l0_r <= l0_nxt;  x0_r <= x0_nxt;  len_r <= len_nxt;  num_r <= num_nxt;
    f_r <= f_nxt;  tph_r <= tph_nxt;  poly_r <= poly_nxt;  x_r <= x_nxt;
    n_r <= n_nxt;  term_r <= term_nxt;  e_r <= e_nxt;  th_r <= th_nxt;
    sum_r <= sum_nxt;  k_r <= k_nxt;  iter_r <= iter_nxt;
    sq_v_r <= sq_v_nxt;  sq_root_r <= sq_root_nxt;  sq_bit_r <= sq_bit_nxt;
    sq_cnt_r <= sq_cnt_nxt;
  end

  assign out_wave_length   = len_r;
  assign out_wave_number   = num_r;
  assign out_amplitude_out = amp_r;
  assign out_phase_out     = ph_r;
  assign out_bad_input     = bad_r;
  assign out_last_out      = last_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result shown for more than one cycle");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_input) |-> (out_wave_length == 32'd0 && out_wave_number == 32'd0))
    else $error("bad input with nonzero result");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.go && div_req.go)) else $error("both units started at once");
endmodule

// File: bench/tb_top.sv
// Testbench for wave_dispersion_solver: directed and random wave components
// checked against a bit-exact dispersion predictor. Depends on the RTL only.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [31:0] wave_length;
    logic [31:0] wave_number;
    logic [23:0] amplitude;
    logic [23:0] phase;
    logic        bad_input;
    logic        last;
  } wave_result_t;

  localparam longint unsigned TWO_PI = 64'd26986075409;
  localparam longint unsigned TWO_PI_G = 64'd264733399763;
  localparam longint unsigned INV_E = 64'd1580030169;
  localparam longint unsigned ONE = 64'h1_0000_0000;
  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam int unsigned SOLVE_PASSES = 100;
  localparam logic [23:0] DEPTH_AT_RESET = 24'd40960;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_amplitude = '0;
  logic [23:0] in_angular_frequency = '0;
  logic [23:0] in_phase = '0;
  logic in_last_component = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;
  logic out_valid;
  logic [31:0] out_wave_length;
  logic [31:0] out_wave_number;
  logic [23:0] out_amplitude_out;
  logic [23:0] out_phase_out;
  logic out_bad_input;
  logic out_last_out;

  wave_result_t expected_waves[$];
  logic [23:0] depth_model;
  int unsigned mismatches = 0;
  bit allow_gaps = 1'b1;

  wave_dispersion_solver dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Time limit: far beyond the slowest correct run.
  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned exp_neg_fraction(longint unsigned f);
    longint unsigned term;
    longint sum;
    term = ONE;
    sum = longint'(ONE);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * f) >> 32) / longint'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE)) sum = longint'(ONE);
    return longint'(sum);
  endfunction

  // tanh of a Q26 argument, result Q32
  function automatic longint unsigned tanh_fixed(longint unsigned x);
    longint unsigned y, n, e;
    if (x >= (64'd12 << 26)) return ONE;
    y = x << 7;
    n = y >> 32;
    e = exp_neg_fraction(y & MASK32);
    for (longint unsigned i = 0; i < n; i++) e = (e * INV_E + (64'd1 << 31)) >> 32;
    if (e == 0) return ONE;
    return (((ONE - e) << 32) + ((ONE + e) >> 1)) / (ONE + e);
  endfunction

  function automatic longint unsigned depth_over_length(longint unsigned h,
                                                         longint unsigned len);
    if (len == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return (TWO_PI * h) / len;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic wave_result_t solve_wave(logic [23:0] amp, logic [23:0] freq,
                                              logic [23:0] ph, logic last);
    wave_result_t res;
    longint unsigned w, h, w2, l0, x0, root, poly, s0, len, num;
    w = freq;
    h = (depth_model == 0) ? 64'd1 : depth_model;
    len = 0;
    num = 0;
    if (w != 0) begin
      w2 = w * w;
      l0 = ((TWO_PI_G << 22) + (w2 >> 1)) / w2;
      if (l0 > MASK32) l0 = MASK32;
      x0 = depth_over_length(h, l0);
      if (x0 > MASK32) x0 = MASK32;
      root = int_sqrt(x0 << 26);
      poly = (64'd1 << 26) + x0 / 6 + ((x0 * x0) >> 26) / 30;
      s0 = (root * poly) >> 26;
      len = (l0 * tanh_fixed(s0)) >> 32;
      for (int i = 0; i < SOLVE_PASSES; i++)
        len = (l0 * tanh_fixed(depth_over_length(h, len))) >> 32;
      if (len == 0) begin
        num = MASK32;
      end else begin
        num = ((TWO_PI << 10) + (len >> 1)) / len;
        if (num > MASK32) num = MASK32;
      end
    end
    res.wave_length = len[31:0];
    res.wave_number = num[31:0];
    res.amplitude = amp;
    res.phase = ph;
    res.bad_input = (w == 0);
    res.last = last;
    return res;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    wave_result_t want;
    if (rst_n && out_valid) begin
      if (expected_waves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: length %h", out_wave_length);
      end else begin
        want = expected_waves.pop_front();
        if (out_wave_length !== want.wave_length || out_wave_number !== want.wave_number ||
            out_amplitude_out !== want.amplitude || out_phase_out !== want.phase ||
            out_bad_input !== want.bad_input || out_last_out !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp L=%h k=%h a=%h p=%h bad=%b last=%b, got L=%h k=%h a=%h p=%h bad=%b last=%b",
                     want.wave_length, want.wave_number, want.amplitude, want.phase,
                     want.bad_input, want.last, out_wave_length, out_wave_number,
                     out_amplitude_out, out_phase_out, out_bad_input, out_last_out);
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  // Present one component; returns at the edge where it is taken, or after a random gap with start low.
  task automatic send_component(logic [23:0] amp, logic [23:0] freq, logic [23:0] ph,
                                logic last);
    start <= 1'b1;
    in_amplitude <= amp;
    in_angular_frequency <= freq;
    in_phase <= ph;
    in_last_component <= last;
    do @(negedge clk); while (busy);
    @(posedge clk);
    expected_waves.push_back(solve_wave(amp, freq, ph, last));
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Wait for all results, then write the depth register.
  task automatic set_depth(logic [23:0] value);
    @(posedge clk);
    start <= 1'b0;
    wait (expected_waves.size() == 0);
    repeat (8) @(posedge clk);
    do @(negedge clk); while (busy);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    depth_model = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_frequency();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return 24'($urandom);
      3: return 24'($urandom_range(1, 4096));
      default: return 24'($urandom_range(26214, 2621440));  // 0.1 .. 10 rad/s
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_depth();
    send_component(24'h7FFFFF, 24'd262144, 24'h800000, 1'b0);
    send_component(24'h800000, 24'd0, 24'h7FFFFF, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_component(24'h000000, 24'd1, 24'h000000, 1'b0);
    send_component(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_component(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
    send_component(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
    send_component(24'h000001, 24'd26214, 24'h000001, 1'b0);
  endtask

  task automatic test_depth_extremes();
    set_depth(24'd1);             // shallowest
    send_component(24'h010000, 24'd262144, 24'h000000, 1'b0);
    send_component(24'h010000, 24'hFFFFFF, 24'h000000, 1'b0);
    send_component(24'h010000, 24'd0, 24'h000000, 1'b1);
    set_depth(24'hFFFFFF);        // deepest
    send_component(24'h010000, 24'd1, 24'h000000, 1'b0);
    send_component(24'h010000, 24'd131072, 24'h100000, 1'b0);
    send_component(24'h010000, 24'd2621440, 24'h100000, 1'b1);
    set_depth(DEPTH_AT_RESET);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 10) set_depth(24'($urandom_range(1, 24'hFFFFFF)));
      if (i == count - 15) allow_gaps = 1'b0;
      send_component(24'($urandom), pick_frequency(), 24'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    depth_model = DEPTH_AT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_depth();
    test_field_extremes();
    test_depth_extremes();
    test_random(85);
    @(posedge clk);
    start <= 1'b0;
    wait (expected_waves.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: wave_dispersion_solver.f
src/wds_pkg.sv
src/wds_mul.sv
src/wds_div.sv
src/wave_dispersion_solver.sv
bench/tb_top.sv
